// ===== rtl/hsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg
// Types and constants shared by the hexagonal spiral index converter.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int INDEX_W   = 22;
    localparam int COORD_W   = 11;
    localparam int RING_W    = 10;
    localparam int WIDE_W    = 14;
    localparam int ABS_W     = 13;

    localparam logic [RING_W-1:0]  MAX_RING   = 10'd1023;
    localparam logic [INDEX_W-1:0] INDEX_LIMIT = 22'd3142656;

    localparam logic FUNC_TO_COORD = 1'b0;
    localparam logic FUNC_TO_INDEX = 1'b1;

    typedef struct packed {
        logic                      func;
        logic                      ioor;
        logic                      izero;
        logic [INDEX_W-1:0]        idx;
        logic [RING_W-1:0]         r0;
        logic signed [WIDE_W-1:0]  cu;
        logic signed [WIDE_W-1:0]  cv;
    } srch_t;

endpackage

// ===== rtl/hex_spiral_index_axial_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_spiral_index_axial_convert
// Spiral cell index to axial coordinates and back on a hexagonal grid.
// ----------------------------------------------------------------------------
// Each beat converts one way, chosen by func, and produces one result beat.
// The block is a 16 stage pipeline that takes a new beat every cycle unless
// the output stalls, and each result comes from a registered output; the
// ring of an index is found by a ten stage bit-by-bit search, one ring bit per
// stage. An output stall while a result is valid freezes the whole pipeline.
// The clockwise register must only be written while no beat is in flight.
module hex_spiral_index_axial_convert
    import hsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic [INDEX_W-1:0]        index_in,
    input  logic signed [COORD_W-1:0] u_in,
    input  logic signed [COORD_W-1:0] v_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [INDEX_W-1:0]        index_out,
    output logic signed [COORD_W-1:0] u_out,
    output logic signed [COORD_W-1:0] v_out,
    output logic [RING_W-1:0]         ring,
    output logic                      out_of_range
);

    localparam int N_STG = RING_W + 6;

    logic               clockwise_reg;
    logic [N_STG-1:0]   vld_reg;
    logic               en;
    srch_t              srch_reg [0:RING_W];

    assign en        = !vld_reg[N_STG-1] || !out_stall;
    assign in_stall  = !en;
    assign out_valid = vld_reg[N_STG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clockwise_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            clockwise_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N_STG-2:0], in_valid};
        end
    end

    // Input stage: range check of the index and mirroring of the coordinates.
    srch_t in_next;
    always_comb
    begin
        logic signed [WIDE_W-1:0] u_w;
        logic signed [WIDE_W-1:0] v_w;
        u_w = WIDE_W'(u_in);
        v_w = WIDE_W'(v_in);
        in_next.func  = func;
        in_next.idx   = index_in;
        in_next.ioor  = index_in > INDEX_LIMIT;
        in_next.izero = index_in == '0;
        in_next.r0    = '0;
        if (clockwise_reg)
        begin
            in_next.cu = u_w + v_w;
            in_next.cv = -v_w;
        end
        else
        begin
            in_next.cu = u_w;
            in_next.cv = v_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srch_reg[0] <= in_next;
        end
    end

    // Ring search: r0 is the largest value with 3*r0*(r0+1) below the index.
    for (genvar k = 0; k < RING_W; k++)
    begin : g_srch
        localparam int B = RING_W - 1 - k;
        srch_t srch_next;
        always_comb
        begin
            logic [RING_W-1:0]    cand;
            logic [RING_W:0]      cand_p1;
            logic [2*RING_W:0]    prod;
            logic [INDEX_W:0]     prod3;
            cand    = srch_reg[k].r0 | (RING_W'(1) << B);
            cand_p1 = {1'b0, cand} + (RING_W+1)'(1);
            prod    = (2*RING_W+1)'(cand) * (2*RING_W+1)'(cand_p1);
            prod3   = (INDEX_W+1)'({prod, 1'b0}) + (INDEX_W+1)'(prod);
            srch_next = srch_reg[k];
            if (prod3 < {1'b0, srch_reg[k].idx})
            begin
                srch_next.r0 = cand;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srch_reg[k+1] <= srch_next;
            end
        end
    end

    // Stage P1: ring base of the index; absolute values of the coordinates.
    logic                      p1_func_reg, p1_ioor_reg, p1_izero_reg;
    logic [INDEX_W-1:0]        p1_idx_reg, p1_base_reg;
    logic [RING_W-1:0]         p1_r_reg;
    logic signed [WIDE_W-1:0]  p1_u_reg, p1_v_reg, p1_upv_reg;
    logic [ABS_W-1:0]          p1_au_reg, p1_av_reg, p1_aupv_reg;

    logic [INDEX_W-1:0]        p1_base_next;
    logic signed [WIDE_W-1:0]  p1_upv_next;
    always_comb
    begin
        logic [RING_W:0]      r0_p1;
        logic [2*RING_W:0]    prod;
        r0_p1        = {1'b0, srch_reg[RING_W].r0} + (RING_W+1)'(1);
        prod         = (2*RING_W+1)'(srch_reg[RING_W].r0) * (2*RING_W+1)'(r0_p1);
        p1_base_next = INDEX_W'({prod, 1'b0}) + INDEX_W'(prod);
        p1_upv_next  = srch_reg[RING_W].cu + srch_reg[RING_W].cv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_func_reg  <= srch_reg[RING_W].func;
            p1_ioor_reg  <= srch_reg[RING_W].ioor;
            p1_izero_reg <= srch_reg[RING_W].izero;
            p1_idx_reg   <= srch_reg[RING_W].idx;
            p1_r_reg     <= srch_reg[RING_W].r0 + RING_W'(1);
            p1_base_reg  <= p1_base_next;
            p1_u_reg     <= srch_reg[RING_W].cu;
            p1_v_reg     <= srch_reg[RING_W].cv;
            p1_upv_reg   <= p1_upv_next;
            p1_au_reg    <= srch_reg[RING_W].cu[WIDE_W-1] ?
                            ABS_W'(-srch_reg[RING_W].cu) : ABS_W'(srch_reg[RING_W].cu);
            p1_av_reg    <= srch_reg[RING_W].cv[WIDE_W-1] ?
                            ABS_W'(-srch_reg[RING_W].cv) : ABS_W'(srch_reg[RING_W].cv);
            p1_aupv_reg  <= p1_upv_next[WIDE_W-1] ?
                            ABS_W'(-p1_upv_next) : ABS_W'(p1_upv_next);
        end
    end

    // Stage P2: offset inside the ring and its segment bounds; coordinate ring.
    logic                      p2_func_reg, p2_ioor_reg, p2_izero_reg;
    logic [ABS_W-1:0]          p2_off_reg, p2_m3_reg, p2_m5_reg;
    logic [RING_W-1:0]         p2_r_reg;
    logic signed [WIDE_W-1:0]  p2_u_reg, p2_v_reg, p2_upv_reg;
    logic [ABS_W-1:0]          p2_cr_reg;
    logic                      p2_coor_reg, p2_czero_reg;

    logic [ABS_W-1:0]          p2_cr_next;
    logic [INDEX_W-1:0]        p2_off_next;
    always_comb
    begin
        p2_cr_next = p1_au_reg;
        if (p1_av_reg > p2_cr_next)
        begin
            p2_cr_next = p1_av_reg;
        end
        if (p1_aupv_reg > p2_cr_next)
        begin
            p2_cr_next = p1_aupv_reg;
        end
        p2_off_next = p1_idx_reg - p1_base_reg - INDEX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_func_reg  <= p1_func_reg;
            p2_ioor_reg  <= p1_ioor_reg;
            p2_izero_reg <= p1_izero_reg;
            p2_off_reg   <= p2_off_next[ABS_W-1:0];
            p2_r_reg     <= p1_r_reg;
            p2_m3_reg    <= ABS_W'({p1_r_reg, 1'b0}) + ABS_W'(p1_r_reg);
            p2_m5_reg    <= ABS_W'({p1_r_reg, 2'b0}) + ABS_W'(p1_r_reg);
            p2_u_reg     <= p1_u_reg;
            p2_v_reg     <= p1_v_reg;
            p2_upv_reg   <= p1_upv_reg;
            p2_cr_reg    <= p2_cr_next;
            p2_coor_reg  <= p2_cr_next > ABS_W'(MAX_RING);
            p2_czero_reg <= p2_cr_next == '0;
        end
    end

    // Stage P3: segment and run in both directions.
    logic                      p3_func_reg, p3_ioor_reg, p3_izero_reg;
    logic [2:0]                p3_seg_reg, p3_cseg_reg;
    logic [RING_W-1:0]         p3_run_reg, p3_crun_reg, p3_r_reg, p3_cr_reg;
    logic [2*RING_W-1:0]       p3_rr_reg;
    logic                      p3_coor_reg, p3_czero_reg;

    logic [2:0]                seg_next, cseg_next;
    logic [ABS_W-1:0]          run_next;
    logic signed [WIDE_W-1:0]  crun_next;
    logic [RING_W-1:0]         cr10;
    always_comb
    begin
        logic [ABS_W-1:0]         m1, m2, m4;
        logic signed [WIDE_W-1:0] rs;
        m1 = ABS_W'(p2_r_reg);
        m2 = ABS_W'({p2_r_reg, 1'b0});
        m4 = ABS_W'({p2_r_reg, 2'b0});
        priority if (p2_off_reg >= p2_m5_reg)
        begin
            seg_next = 3'd5; run_next = p2_off_reg - p2_m5_reg;
        end
        else if (p2_off_reg >= m4)
        begin
            seg_next = 3'd4; run_next = p2_off_reg - m4;
        end
        else if (p2_off_reg >= p2_m3_reg)
        begin
            seg_next = 3'd3; run_next = p2_off_reg - p2_m3_reg;
        end
        else if (p2_off_reg >= m2)
        begin
            seg_next = 3'd2; run_next = p2_off_reg - m2;
        end
        else if (p2_off_reg >= m1)
        begin
            seg_next = 3'd1; run_next = p2_off_reg - m1;
        end
        else
        begin
            seg_next = 3'd0; run_next = p2_off_reg;
        end

        rs   = WIDE_W'(p2_cr_reg);
        cr10 = p2_cr_reg[RING_W-1:0];
        priority if (p2_upv_reg == rs && p2_v_reg != rs)
        begin
            cseg_next = 3'd0; crun_next = p2_v_reg;
        end
        else if (p2_v_reg == rs && p2_u_reg != -rs)
        begin
            cseg_next = 3'd1; crun_next = -p2_u_reg;
        end
        else if (p2_u_reg == -rs && p2_upv_reg != -rs)
        begin
            cseg_next = 3'd2; crun_next = rs - p2_v_reg;
        end
        else if (p2_upv_reg == -rs && p2_v_reg != -rs)
        begin
            cseg_next = 3'd3; crun_next = -p2_v_reg;
        end
        else if (p2_v_reg == -rs && p2_u_reg != rs)
        begin
            cseg_next = 3'd4; crun_next = p2_u_reg;
        end
        else
        begin
            cseg_next = 3'd5; crun_next = rs + p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_func_reg  <= p2_func_reg;
            p3_ioor_reg  <= p2_ioor_reg;
            p3_izero_reg <= p2_izero_reg;
            p3_seg_reg   <= seg_next;
            p3_run_reg   <= run_next[RING_W-1:0];
            p3_r_reg     <= p2_r_reg;
            p3_cseg_reg  <= cseg_next;
            p3_crun_reg  <= crun_next[RING_W-1:0];
            p3_cr_reg    <= cr10;
            p3_rr_reg    <= (2*RING_W)'(cr10) * (2*RING_W)'(cr10 - RING_W'(1));
            p3_coor_reg  <= p2_coor_reg;
            p3_czero_reg <= p2_czero_reg;
        end
    end

    // Stage P4: coordinates of the index; index of the coordinates.
    logic                      p4_func_reg, p4_ioor_reg, p4_izero_reg;
    logic signed [WIDE_W-1:0]  p4_u_reg, p4_v_reg;
    logic [RING_W-1:0]         p4_r_reg, p4_cr_reg;
    logic [INDEX_W-1:0]        p4_cidx_reg;
    logic                      p4_coor_reg, p4_czero_reg;

    logic signed [WIDE_W-1:0]  u_next, v_next;
    logic [INDEX_W-1:0]        cidx_next;
    always_comb
    begin
        logic signed [WIDE_W-1:0] r;
        logic signed [WIDE_W-1:0] k;
        logic signed [WIDE_W-1:0] u;
        logic signed [WIDE_W-1:0] v;
        r = WIDE_W'(p3_r_reg);
        k = WIDE_W'(p3_run_reg);
        unique case (p3_seg_reg)
            3'd0:    begin u = r - k; v = k;     end
            3'd1:    begin u = -k;    v = r;     end
            3'd2:    begin u = -r;    v = r - k; end
            3'd3:    begin u = k - r; v = -k;    end
            3'd4:    begin u = k;     v = -r;    end
            default: begin u = r;     v = k - r; end
        endcase
        if (clockwise_reg)
        begin
            u_next = u + v;
            v_next = -v;
        end
        else
        begin
            u_next = u;
            v_next = v;
        end
        cidx_next = INDEX_W'({p3_rr_reg, 1'b0}) + INDEX_W'(p3_rr_reg) + INDEX_W'(1)
                  + INDEX_W'(p3_cseg_reg) * INDEX_W'(p3_cr_reg) + INDEX_W'(p3_crun_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_func_reg  <= p3_func_reg;
            p4_ioor_reg  <= p3_ioor_reg;
            p4_izero_reg <= p3_izero_reg;
            p4_u_reg     <= u_next;
            p4_v_reg     <= v_next;
            p4_r_reg     <= p3_r_reg;
            p4_cr_reg    <= p3_cr_reg;
            p4_cidx_reg  <= cidx_next;
            p4_coor_reg  <= p3_coor_reg;
            p4_czero_reg <= p3_czero_reg;
        end
    end

    // Output register: select the direction, clear fields on a range error.
    logic [INDEX_W-1:0]        index_out_reg;
    logic signed [COORD_W-1:0] u_out_reg, v_out_reg;
    logic [RING_W-1:0]         ring_reg;
    logic                      oor_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            index_out_reg <= '0;
            u_out_reg     <= '0;
            v_out_reg     <= '0;
            ring_reg      <= '0;
            oor_reg       <= 1'b0;
            if (p4_func_reg == FUNC_TO_INDEX)
            begin
                if (p4_coor_reg)
                begin
                    oor_reg <= 1'b1;
                end
                else if (!p4_czero_reg)
                begin
                    index_out_reg <= p4_cidx_reg;
                    ring_reg      <= p4_cr_reg;
                end
            end
            else
            begin
                if (p4_ioor_reg)
                begin
                    oor_reg <= 1'b1;
                end
                else if (!p4_izero_reg)
                begin
                    u_out_reg <= p4_u_reg[COORD_W-1:0];
                    v_out_reg <= p4_v_reg[COORD_W-1:0];
                    ring_reg  <= p4_r_reg;
                end
            end
        end
    end

    assign index_out    = index_out_reg;
    assign u_out        = u_out_reg;
    assign v_out        = v_out_reg;
    assign ring         = ring_reg;
    assign out_of_range = oor_reg;

endmodule

// ===== tb/tb_hex_spiral_index_axial_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_spiral_index_axial_convert
// Checks spiral index to axial coordinate conversion in both directions.
// ----------------------------------------------------------------------------
// A directed table of beats covers the origin, ring corners, the range limits
// and both numbering senses. Random beats follow under several idle and stall
// mixes, and every result beat is checked against a local model of the grid.
// ----------------------------------------------------------------------------
module tb_hex_spiral_index_axial_convert;
    import hsc_pkg::*;

    localparam int PIPE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                      oor;
        logic [RING_W-1:0]         ring;
        logic [INDEX_W-1:0]        index;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
    } conv_res_t;

    typedef struct packed {
        logic                      fn;
        logic [INDEX_W-1:0]        index;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
        logic                      known;
        conv_res_t                 res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = FUNC_TO_COORD;
    logic [INDEX_W-1:0] index_in = '0;
    logic signed [COORD_W-1:0] u_in = '0;
    logic signed [COORD_W-1:0] v_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [INDEX_W-1:0] index_out;
    logic signed [COORD_W-1:0] u_out;
    logic signed [COORD_W-1:0] v_out;
    logic [RING_W-1:0] ring;
    logic out_of_range;

    logic cw_mode = 1'b0;
    conv_res_t pending_results[$];
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    hex_spiral_index_axial_convert u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .index_in(index_in),
        .u_in(u_in), .v_in(v_in), .out_valid(out_valid), .out_stall(out_stall),
        .index_out(index_out), .u_out(u_out), .v_out(v_out), .ring(ring),
        .out_of_range(out_of_range)
    );

    always #6 clk = ~clk;

    function automatic longint labs(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic conv_res_t convert(logic fn, logic [INDEX_W-1:0] idx_i,
                                          logic signed [COORD_W-1:0] ui,
                                          logic signed [COORD_W-1:0] vi);
        conv_res_t res;
        longint idx, r, lo, hi, mid, off, seg, run, u, v, upv;
        res = '0;
        if (fn == FUNC_TO_COORD) begin
            idx = idx_i;
            u = 0;
            v = 0;
            r = 0;
            if (idx > 3 * 1023 * 1024) begin
                res.oor = 1'b1;
                return res;
            end
            if (idx != 0) begin
                lo = 1;
                hi = 1023;
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (3 * mid * (mid + 1) >= idx) hi = mid;
                    else lo = mid + 1;
                end
                r = lo;
                off = idx - (3 * r * (r - 1) + 1);
                seg = off / r;
                run = off % r;
                case (seg)
                    0: begin u = r - run; v = run; end
                    1: begin u = -run; v = r; end
                    2: begin u = -r; v = r - run; end
                    3: begin u = run - r; v = -run; end
                    4: begin u = run; v = -r; end
                    default: begin u = r; v = run - r; end
                endcase
                if (cw_mode) begin
                    u = u + v;
                    v = -v;
                end
            end
            res.u = u[COORD_W-1:0];
            res.v = v[COORD_W-1:0];
            res.ring = r[RING_W-1:0];
        end else begin
            u = ui;
            v = vi;
            if (cw_mode) begin
                u = u + v;
                v = -v;
            end
            upv = u + v;
            r = labs(u);
            if (labs(v) > r) r = labs(v);
            if (labs(upv) > r) r = labs(upv);
            if (r > 1023) begin
                res.oor = 1'b1;
                return res;
            end
            idx = 0;
            if (r != 0) begin
                if (upv == r && v != r) begin seg = 0; run = v; end
                else if (v == r && u != -r) begin seg = 1; run = -u; end
                else if (u == -r && upv != -r) begin seg = 2; run = r - v; end
                else if (upv == -r && v != -r) begin seg = 3; run = -v; end
                else if (v == -r && u != r) begin seg = 4; run = u; end
                else begin seg = 5; run = r + v; end
                idx = 3 * r * (r - 1) + 1 + seg * r + run;
            end
            res.index = idx[INDEX_W-1:0];
            res.ring = r[RING_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    task automatic send_beat(logic fn, logic [INDEX_W-1:0] idx,
                             logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v,
                             logic known, conv_res_t want);
        conv_res_t pred;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pred = convert(fn, idx, u, v);
        if (known && pred != want)
            report_mismatch("table entry vs model", pred, want);
        pending_results.push_back(known ? want : pred);
        in_valid <= 1'b1;
        func <= fn;
        index_in <= idx;
        u_in <= u;
        v_in <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_and_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_sense(logic cw);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cw;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cw_mode = cw;
    endtask

    task automatic random_run(int count);
        int kind;
        logic [INDEX_W-1:0] idx;
        logic signed [COORD_W-1:0] u, v;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(9, 0);
            idx = INDEX_W'($urandom);
            u = COORD_W'($urandom);
            v = COORD_W'($urandom);
            case (kind)
                0: idx = INDEX_W'($urandom_range(200, 0));
                1: idx = INDEX_W'($urandom_range(3142656, 3142656 - 3000));
                2: idx = INDEX_W'($urandom_range(4194303, 3142657));
                3: idx = INDEX_W'($urandom_range(3142656, 0));
                4: begin u = $signed(11'($urandom_range(8, 0))) - 11'sd4;
                         v = $signed(11'($urandom_range(8, 0))) - 11'sd4; end
                default: ;
            endcase
            send_beat(kind < 4 ? FUNC_TO_COORD : FUNC_TO_INDEX, idx, u, v, 1'b0, '0);
        end
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout at cycle %0d", cycles);
            $display("Verification failed");
            $finish;
        end
        out_stall <= (recv_stall_pct > 0) && ($urandom_range(99, 0) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", index_out, 0);
            end else begin
                conv_res_t want;
                want = pending_results.pop_front();
                if (index_out !== want.index) report_mismatch("index_out", index_out, want.index);
                if (u_out !== want.u) report_mismatch("u_out", u_out, want.u);
                if (v_out !== want.v) report_mismatch("v_out", v_out, want.v);
                if (ring !== want.ring) report_mismatch("ring", ring, want.ring);
                if (out_of_range !== want.oor)
                    report_mismatch("out_of_range", out_of_range, want.oor);
            end
        end
    end

    dir_row_t dir_table[] = '{
        '{FUNC_TO_COORD, 22'd0, 11'sd0, 11'sd0, 1'b1, '{1'b0, 10'd0, 22'd0, 11'sd0, 11'sd0}},
        '{FUNC_TO_COORD, 22'd1, 11'sd0, 11'sd0, 1'b1, '{1'b0, 10'd1, 22'd0, 11'sd1, 11'sd0}},
        '{FUNC_TO_COORD, 22'd6, 11'sd0, 11'sd0, 1'b1, '{1'b0, 10'd1, 22'd0, 11'sd1, -11'sd1}},
        '{FUNC_TO_COORD, 22'd7, 11'sd0, 11'sd0, 1'b1, '{1'b0, 10'd2, 22'd0, 11'sd2, 11'sd0}},
        '{FUNC_TO_COORD, 22'd3142656, 11'sd0, 11'sd0, 1'b0, '0},
        '{FUNC_TO_COORD, 22'd3142657, 11'sd0, 11'sd0, 1'b1, '{1'b1, 10'd0, 22'd0, 11'sd0, 11'sd0}},
        '{FUNC_TO_COORD, 22'h3FFFFF, 11'sd0, 11'sd0, 1'b1, '{1'b1, 10'd0, 22'd0, 11'sd0, 11'sd0}},
        '{FUNC_TO_COORD, 22'd3136519, 11'sd0, 11'sd0, 1'b0, '0},
        '{FUNC_TO_COORD, 22'd1000000, 11'sd0, 11'sd0, 1'b0, '0},
        '{FUNC_TO_INDEX, 22'h3FFFFF, 11'sd0, 11'sd0, 1'b1, '{1'b0, 10'd0, 22'd0, 11'sd0, 11'sd0}},
        '{FUNC_TO_INDEX, 22'd0, 11'sd1, 11'sd0, 1'b1, '{1'b0, 10'd1, 22'd1, 11'sd0, 11'sd0}},
        '{FUNC_TO_INDEX, 22'd0, -11'sd1024, 11'sd0, 1'b1, '{1'b1, 10'd0, 22'd0, 11'sd0, 11'sd0}},
        '{FUNC_TO_INDEX, 22'd0, 11'sd1023, 11'sd1023, 1'b1,
          '{1'b1, 10'd0, 22'd0, 11'sd0, 11'sd0}},
        '{FUNC_TO_INDEX, 22'd0, 11'sd1023, 11'sd0, 1'b0, '0},
        '{FUNC_TO_INDEX, 22'd0, -11'sd1023, 11'sd0, 1'b0, '0},
        '{FUNC_TO_INDEX, 22'd0, 11'sd0, -11'sd1024, 1'b0, '0},
        '{FUNC_TO_INDEX, 22'd0, 11'sd1023, -11'sd1023, 1'b0, '0},
        '{FUNC_TO_INDEX, 22'd0, -11'sd1023, 11'sd1023, 1'b0, '0},
        '{FUNC_TO_INDEX, 22'd0, -11'sd1024, -11'sd1024, 1'b0, '0},
        '{FUNC_TO_INDEX, 22'd0, 11'sd0, 11'sd1023, 1'b0, '0},
        '{FUNC_TO_INDEX, 22'd0, -11'sd512, 11'sd700, 1'b0, '0},
        '{FUNC_TO_INDEX, 22'd0, 11'sd3, -11'sd5, 1'b0, '0}
    };

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int cw = 0; cw < 2; cw++) begin
            if (cw == 1) write_sense(1'b1);
            foreach (dir_table[i])
                send_beat(dir_table[i].fn, dir_table[i].index, dir_table[i].u,
                          dir_table[i].v, dir_table[i].known && cw == 0, dir_table[i].res);
            drain_and_idle();
        end
        write_sense(1'b0);
        random_run(300);
        drain_and_idle();
        write_sense(1'b1);
        send_idle_pct = 75;
        random_run(200);
        drain_and_idle();
        send_idle_pct = 0;
        recv_stall_pct = 75;
        random_run(300);
        drain_and_idle();
        write_sense(1'b0);
        send_idle_pct = 7;
        recv_stall_pct = 7;
        random_run(250);
        drain_and_idle();
        write_sense(1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_run(200);
        drain_and_idle();
        recv_stall_pct = 0;
        repeat (PIPE_DEPTH * 2) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
